[hdl/mono_exposure_statistics_top_assert.svh]
// Assertion macros for the mono exposure statistics block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef MONO_EXPOSURE_STATISTICS_TOP_ASSERT_SVH
`define MONO_EXPOSURE_STATISTICS_TOP_ASSERT_SVH

// Condition must never be true at a clock edge outside reset.
`define MES_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mes assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define MES_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mes assertion failed");

`endif

[hdl/mes_pkg.sv]
// Shared widths, constants and types of the mono exposure statistics block.
// No dependencies.
package mes_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int MEAN_W    = 8;
  localparam int FRAC_W    = 17;
  localparam int TOTAL_W   = 13;
  localparam int STEP_W    = $clog2(FRAC_W);

  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

  localparam logic [PIX_W-1:0]  BRIGHT_LEVEL = 8'd240;
  localparam logic [MEAN_W-1:0] DEFAULT_MEAN = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/mes_if.sv]
// Stream interfaces of the mono exposure statistics block: pixel and result.
// Depends on mes_pkg.
interface mes_pix_if;
  logic                        valid;
  logic                        ready;
  logic [mes_pkg::PIX_W-1:0]   pixel;
  logic                        frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface mes_res_if;
  logic                        valid;
  logic                        ready;
  logic [mes_pkg::MEAN_W-1:0]  mean_brightness;
  logic [mes_pkg::FRAC_W-1:0]  bright_fraction;
  logic [mes_pkg::TOTAL_W-1:0] sample_total;
  logic                        has_samples;

  modport source (output valid, output mean_brightness, output bright_fraction,
                  output sample_total, output has_samples, input ready);
  modport sink (input valid, input mean_brightness, input bright_fraction,
                input sample_total, input has_samples, output ready);
endinterface

[hdl/mes_front.sv]
// Front end: frame size registers, raster position tracking, grid sampling
// and per-frame accumulation. Depends on mes_pkg and mes_if.
module mes_front #(
  parameter int MAX_DIM      = 4096,
  parameter int GRID_COLUMNS = 40,
  parameter int GRID_LINES   = 30,
  parameter int CNT_W        = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mes_pkg::cfg_wr_t     cfg_i,
  mes_pix_if.sink              pix,
  input  mes_pkg::q_stat_t     q_stat_i,
  output logic                 push_o,
  output logic [CNT_W+7:0]     rec_sum_o,
  output logic [CNT_W-1:0]     rec_cnt_o,
  output logic [CNT_W-1:0]     rec_bri_o
);

  localparam int SUM_W = CNT_W + 8;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int CMP_W = DIM_W + 1;
  localparam int PRD_W = 2 * DIM_W + 1;
  localparam int XD    = GRID_COLUMNS + 1;
  localparam int YD    = GRID_LINES + 1;
  localparam int XL    = $clog2(XD);
  localparam int YL    = $clog2(YD);
  // Reciprocals exact for every DIM_W-bit dividend
  localparam longint unsigned XM = ((64'd1 << (DIM_W + XL)) + XD - 1) / XD;
  localparam longint unsigned YM = ((64'd1 << (DIM_W + YL)) + YD - 1) / YD;
  localparam int W_RST  = (mes_pkg::RST_WIDTH > MAX_DIM) ? MAX_DIM : mes_pkg::RST_WIDTH;
  localparam int H_RST  = (mes_pkg::RST_HEIGHT > MAX_DIM) ? MAX_DIM : mes_pkg::RST_HEIGHT;
  localparam int XS_RST = W_RST / XD;
  localparam int YS_RST = H_RST / YD;

  logic [DIM_W-1:0] width_q, height_q, xstep_q, ystep_q;
  logic [DIM_W-1:0] width_d, height_d, xstep_d, ystep_d;
  logic [POS_W-1:0] col_q, row_q, col_d, row_d, col_e, row_e;
  logic [DIM_W-1:0] cph_q, rph_q, cph_d, rph_d, cph_e, rph_e, cph_n, rph_n;
  logic [SUM_W-1:0] sum_q, sum_d, sum_e, sum_n;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_e, cnt_n;
  logic [CNT_W-1:0] bri_q, bri_d, bri_e, bri_n;
  logic [DIM_W-1:0] cfg_size;
  logic [DIM_W:0]   recip;
  logic [PRD_W-1:0] prod;
  logic [DIM_W-1:0] new_step;
  logic [CMP_W-1:0] col_inc, row_inc, cph_inc, rph_inc;
  logic             take, end_line, end_frame, accept;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [mes_pkg::CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // Size and step registers: step is taken with the write
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    xstep_d  = xstep_q;
    ystep_d  = ystep_q;
    cfg_size = clamp_size(cfg_i.data);
    recip    = (cfg_i.idx == mes_pkg::REG_FRAME_HEIGHT) ? (DIM_W + 1)'(YM) : (DIM_W + 1)'(XM);
    prod     = PRD_W'(cfg_size) * PRD_W'(recip);
    new_step = (cfg_i.idx == mes_pkg::REG_FRAME_HEIGHT) ? DIM_W'(prod >> (DIM_W + YL))
                                                        : DIM_W'(prod >> (DIM_W + XL));
    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        mes_pkg::REG_FRAME_WIDTH: begin
          width_d = cfg_size;
          xstep_d = new_step;
        end
        mes_pkg::REG_FRAME_HEIGHT: begin
          height_d = cfg_size;
          ystep_d  = new_step;
        end
        default: ;
      endcase
    end
  end

  assign accept    = pix.valid && pix.ready;
  assign pix.ready = !q_stat_i.full;

  always_comb begin
    // frame_start clears position and sums before the pixel is taken
    col_e = pix.frame_start ? '0 : col_q;
    row_e = pix.frame_start ? '0 : row_q;
    cph_e = pix.frame_start ? '0 : cph_q;
    rph_e = pix.frame_start ? '0 : rph_q;
    sum_e = pix.frame_start ? '0 : sum_q;
    cnt_e = pix.frame_start ? '0 : cnt_q;
    bri_e = pix.frame_start ? '0 : bri_q;

    take  = (xstep_q != '0) && (ystep_q != '0) && (col_e != '0) && (row_e != '0) &&
            (cph_e == '0) && (rph_e == '0);
    sum_n = sum_e + (take ? SUM_W'(pix.pixel) : '0);
    cnt_n = cnt_e + CNT_W'(take);
    bri_n = bri_e + CNT_W'(take && (pix.pixel >= mes_pkg::BRIGHT_LEVEL));

    col_inc   = CMP_W'(col_e) + CMP_W'(1);
    row_inc   = CMP_W'(row_e) + CMP_W'(1);
    end_line  = col_inc >= CMP_W'(width_q);
    end_frame = end_line && (row_inc >= CMP_W'(height_q));

    cph_inc = CMP_W'(cph_e) + CMP_W'(1);
    rph_inc = CMP_W'(rph_e) + CMP_W'(1);
    cph_n   = ((xstep_q == '0) || (cph_inc >= CMP_W'(xstep_q))) ? '0 : DIM_W'(cph_inc);
    rph_n   = ((ystep_q == '0) || (rph_inc >= CMP_W'(ystep_q))) ? '0 : DIM_W'(rph_inc);

    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    bri_d = bri_q;
    if (accept) begin
      priority if (end_frame) begin
        col_d = '0;
        row_d = '0;
        cph_d = '0;
        rph_d = '0;
        sum_d = '0;
        cnt_d = '0;
        bri_d = '0;
      end else if (end_line) begin
        col_d = '0;
        cph_d = '0;
        row_d = POS_W'(row_inc);
        rph_d = rph_n;
        sum_d = sum_n;
        cnt_d = cnt_n;
        bri_d = bri_n;
      end else begin
        col_d = POS_W'(col_inc);
        cph_d = cph_n;
        row_d = row_e;
        rph_d = rph_e;
        sum_d = sum_n;
        cnt_d = cnt_n;
        bri_d = bri_n;
      end
    end
  end

  assign push_o    = accept && end_frame;
  assign rec_sum_o = sum_n;
  assign rec_cnt_o = cnt_n;
  assign rec_bri_o = bri_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(W_RST);
      height_q <= DIM_W'(H_RST);
      xstep_q  <= DIM_W'(XS_RST);
      ystep_q  <= DIM_W'(YS_RST);
      col_q    <= '0;
      row_q    <= '0;
      cph_q    <= '0;
      rph_q    <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      bri_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      xstep_q  <= xstep_d;
      ystep_q  <= ystep_d;
      col_q    <= col_d;
      row_q    <= row_d;
      cph_q    <= cph_d;
      rph_q    <= rph_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      bri_q    <= bri_d;
    end
  end

endmodule

[hdl/mes_queue.sv]
// Two-entry queue of frame totals between front and back end.
// Depends on mes_pkg.
module mes_queue #(
  parameter int DATA_W = 58
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [DATA_W-1:0]  wdata_i,
  input  logic               pop_i,
  output logic [DATA_W-1:0]  rdata_o,
  output mes_pkg::q_stat_t   stat_o
);

  localparam int DEPTH  = 2;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (fill_q == FILL_W'(DEPTH));
  assign stat_o.empty = (fill_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fill_q <= fill_q + FILL_W'(push_i) - FILL_W'(pop_i);
    end
  end

endmodule

[hdl/mes_back.sv]
// Back end: bit-serial division of frame totals into mean and bright share,
// and the result register. Depends on mes_pkg and mes_if.
module mes_back #(
  parameter int CNT_W = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mes_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  input  logic [CNT_W+7:0]   rec_sum_i,
  input  logic [CNT_W-1:0]   rec_cnt_i,
  input  logic [CNT_W-1:0]   rec_bri_i,
  mes_res_if.source          res
);

  localparam int REM_W = CNT_W + mes_pkg::FRAC_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEAN,
    ST_FRAC,
    ST_EMIT
  } state_e;

  state_e                          state_q;
  logic [REM_W-1:0]                rem_q, dvs_q, rem_sub;
  logic [mes_pkg::FRAC_W-1:0]      quot_q, quot_n;
  logic [mes_pkg::STEP_W-1:0]      step_q;
  logic [CNT_W-1:0]                cnt_q, bri_q;
  logic [mes_pkg::MEAN_W-1:0]      mean_q, res_mean_q;
  logic [mes_pkg::FRAC_W-1:0]      frac_q, res_frac_q;
  logic [mes_pkg::TOTAL_W-1:0]     res_total_q;
  logic                            has_q, res_has_q, valid_q, ge;

  assign pop_o   = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign ge      = rem_q >= dvs_q;
  assign rem_sub = rem_q - dvs_q;
  assign quot_n  = {quot_q[mes_pkg::FRAC_W-2:0], ge};

  assign res.valid           = valid_q;
  assign res.mean_brightness = res_mean_q;
  assign res.bright_fraction = res_frac_q;
  assign res.sample_total    = res_total_q;
  assign res.has_samples     = res_has_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      dvs_q       <= '0;
      quot_q      <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      bri_q       <= '0;
      mean_q      <= '0;
      frac_q      <= '0;
      has_q       <= 1'b0;
      valid_q     <= 1'b0;
      res_mean_q  <= '0;
      res_frac_q  <= '0;
      res_total_q <= '0;
      res_has_q   <= 1'b0;
    end else begin
      // drop the result once the beat is taken, unless the next one loads now
      if (valid_q && res.ready && (state_q != ST_EMIT)) begin
        valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            cnt_q  <= rec_cnt_i;
            bri_q  <= rec_bri_i;
            quot_q <= '0;
            if (rec_cnt_i == '0) begin
              mean_q  <= mes_pkg::DEFAULT_MEAN;
              frac_q  <= '0;
              has_q   <= 1'b0;
              state_q <= ST_EMIT;
            end else begin
              // mean < 256, so quotient bits start at bit MEAN_W-1
              rem_q   <= REM_W'(rec_sum_i);
              dvs_q   <= REM_W'(rec_cnt_i) << (mes_pkg::MEAN_W - 1);
              step_q  <= mes_pkg::STEP_W'(mes_pkg::MEAN_W - 1);
              has_q   <= 1'b1;
              state_q <= ST_MEAN;
            end
          end
        end
        ST_MEAN: begin
          if (ge) begin
            rem_q <= rem_sub;
          end
          dvs_q  <= dvs_q >> 1;
          quot_q <= quot_n;
          step_q <= step_q - mes_pkg::STEP_W'(1);
          if (step_q == '0) begin
            mean_q  <= quot_n[mes_pkg::MEAN_W-1:0];
            rem_q   <= REM_W'(bri_q) << (mes_pkg::FRAC_W - 1);
            dvs_q   <= REM_W'(cnt_q) << (mes_pkg::FRAC_W - 1);
            quot_q  <= '0;
            step_q  <= mes_pkg::STEP_W'(mes_pkg::FRAC_W - 1);
            state_q <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          if (ge) begin
            rem_q <= rem_sub;
          end
          dvs_q  <= dvs_q >> 1;
          quot_q <= quot_n;
          step_q <= step_q - mes_pkg::STEP_W'(1);
          if (step_q == '0) begin
            frac_q  <= quot_n;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold until the result register is free
          if (!valid_q || res.ready) begin
            valid_q     <= 1'b1;
            res_mean_q  <= mean_q;
            res_frac_q  <= frac_q;
            res_total_q <= mes_pkg::TOTAL_W'(cnt_q);
            res_has_q   <= has_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/mono_exposure_statistics_top.sv]
// Mono exposure statistics: a pixel stream goes in through pix_i, one pixel
// per beat in raster order, frame_start high on column 0 of line 0 of a frame.
// Grid pixels (nonzero multiples of width/(GRID_COLUMNS+1) across and of
// height/(GRID_LINES+1) down) are summed and counted, and those at or above
// 240 counted apart. After the last pixel of a frame one result beat leaves on
// res_o: truncated mean, bright share in Q1.16, sample count and has_samples
// (mean 128 and zeros when nothing was sampled).
// Pixels are taken one per cycle; pix_i.ready drops only while both entries
// of the frame-total queue are full.
// With the back end idle a result goes through popping the queue, the mean and
// then the share in the shared one-bit-per-cycle divider, and loading the
// result register; a frame with no samples skips the divider.
// A stalled res_o holds its beat; the divider then waits with its next result
// and the queue absorbs up to two more frames.
// Reset sets width 640 and height 480 and clears position and totals.
// Frame size registers are written through cfg_we_i/cfg_idx_i/cfg_data_i.
// Depends on mes_pkg, mes_if, mes_front, mes_queue and mes_back.
`include "mono_exposure_statistics_top_assert.svh"

module mono_exposure_statistics_top #(
  parameter int MAX_DIM      = 4096,
  parameter int GRID_COLUMNS = 40,
  parameter int GRID_LINES   = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mes_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mes_pkg::CFG_W-1:0]         cfg_data_i,
  mes_pix_if.sink                           pix_i,
  mes_res_if.source                         res_o
);

  localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int SUM_W  = CNT_W + 8;
  localparam int DATA_W = SUM_W + 2 * CNT_W;

  mes_pkg::cfg_wr_t  cfg;
  mes_pkg::q_stat_t  q_stat;
  logic              push, pop;
  logic [SUM_W-1:0]  f_sum, b_sum;
  logic [CNT_W-1:0]  f_cnt, f_bri, b_cnt, b_bri;
  logic [DATA_W-1:0] q_rdata;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  mes_front #(
    .MAX_DIM      (MAX_DIM),
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_LINES   (GRID_LINES),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .pix       (pix_i),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .rec_sum_o (f_sum),
    .rec_cnt_o (f_cnt),
    .rec_bri_o (f_bri)
  );

  mes_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_sum, f_cnt, f_bri}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  assign b_sum = q_rdata[DATA_W-1 -: SUM_W];
  assign b_cnt = q_rdata[2*CNT_W-1 -: CNT_W];
  assign b_bri = q_rdata[CNT_W-1:0];

  mes_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .pop_o     (pop),
    .rec_sum_i (b_sum),
    .rec_cnt_i (b_cnt),
    .rec_bri_i (b_bri),
    .res       (res_o)
  );

  `MES_NEVER(a_queue_no_overflow, push && q_stat.full)
  `MES_NEVER(a_queue_flags_exclusive, q_stat.full && q_stat.empty)
  `MES_NEXT(a_pop_then_busy, pop, !pop)
  `MES_NEXT(a_push_lands, push, !q_stat.empty)

endmodule
